// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helper functions of the complex-number ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [3:0] {
    FUNC_ADD   = 4'd0,
    FUNC_SUB   = 4'd1,
    FUNC_MUL   = 4'd2,
    FUNC_DIV   = 4'd3,
    FUNC_SCALE = 4'd4,
    FUNC_CONJ  = 4'd5,
    FUNC_MAG   = 4'd6,
    FUNC_ARG   = 4'd7,
    FUNC_EQUAL = 4'd8
  } func_t;

  // divider: one quotient bit per stage, two bits above the 32-bit range
  localparam int DIV_STEPS = 34;
  localparam int DIV_W     = 64 + DIV_STEPS;
  // square root: one root bit per stage
  localparam int SQRT_STEPS = 32;
  // angle unit: prep stage, normalize stages, two finishing stages
  localparam int NORM_STEPS = 5;
  localparam int ANG_EXTRA  = 1 + NORM_STEPS + 2;
  localparam int CORDIC_W   = 44;

  localparam logic [34:0] Q30_HALF_PI  = 35'd1686629713;
  localparam logic [34:0] Q30_PI       = 35'd3373259426;
  localparam logic [34:0] Q30_3HALF_PI = 35'd5059889139;
  localparam logic [34:0] Q30_TWO_PI   = 35'd6746518852;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               eq;
    logic               sat;
    logic               dz;
  } early_t;

  function automatic sat_t sat65(input logic signed [64:0] v);
    sat_t r;
    if (v > 65'sd2147483647) begin
      r.val = S32_MAX;
      r.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      r.val = S32_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t div_final(input logic neg, input logic [DIV_STEPS-1:0] q);
    sat_t r;
    if (q > DIV_STEPS'(34'h0_8000_0000)) begin
      r.val = neg ? S32_MIN : S32_MAX;
      r.sat = 1'b1;
    end else if (neg) begin
      r.val = 32'd0 - q[31:0];
      r.sat = 1'b0;
    end else if (q == DIV_STEPS'(34'h0_8000_0000)) begin
      r.val = S32_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = q[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/cau_delay.sv -----
// ----------------------------------------------------------------------------
// cau_delay
// Shift-register delay line with a common advance enable.
// ----------------------------------------------------------------------------
module cau_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

// ----- rtl/cau_divider.sv -----
// ----------------------------------------------------------------------------
// cau_divider
// Pipelined restoring divider, one quotient bit per stage, for the real and
// imaginary numerators against a shared divisor.
// ----------------------------------------------------------------------------
module cau_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic                           neg_re,
  input  logic                           neg_im,
  input  logic [63:0]                    mag_re,
  input  logic [63:0]                    mag_im,
  input  logic [63:0]                    d,
  output logic [cau_pkg::DIV_STEPS-1:0]  q_re,
  output logic [cau_pkg::DIV_STEPS-1:0]  q_im,
  output logic                           neg_re_out,
  output logic                           neg_im_out
);

  localparam int STEPS = cau_pkg::DIV_STEPS;
  localparam int RW    = cau_pkg::DIV_W;

  logic [RW-1:0]    rem_re [STEPS];
  logic [RW-1:0]    rem_im [STEPS];
  logic [STEPS-1:0] quo_re [STEPS];
  logic [STEPS-1:0] quo_im [STEPS];
  logic [63:0]      dv     [STEPS];
  logic             nre    [STEPS];
  logic             nim    [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int K = STEPS - 1 - s;
    logic [RW-1:0]    r_re;
    logic [RW-1:0]    r_im;
    logic [RW-1:0]    trial;
    logic [STEPS-1:0] qp_re;
    logic [STEPS-1:0] qp_im;
    logic [63:0]      dp;
    logic             np_re;
    logic             np_im;
    logic             ge_re;
    logic             ge_im;

    if (s == 0) begin : g_src
      assign r_re  = RW'(mag_re) << FRAC_BITS;
      assign r_im  = RW'(mag_im) << FRAC_BITS;
      assign qp_re = '0;
      assign qp_im = '0;
      assign dp    = d;
      assign np_re = neg_re;
      assign np_im = neg_im;
    end else begin : g_src
      assign r_re  = rem_re[s-1];
      assign r_im  = rem_im[s-1];
      assign qp_re = quo_re[s-1];
      assign qp_im = quo_im[s-1];
      assign dp    = dv[s-1];
      assign np_re = nre[s-1];
      assign np_im = nim[s-1];
    end

    assign trial = RW'(dp) << K;
    assign ge_re = r_re >= trial;
    assign ge_im = r_im >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_re[s] <= ge_re ? r_re - trial : r_re;
        rem_im[s] <= ge_im ? r_im - trial : r_im;
        quo_re[s] <= {qp_re[STEPS-2:0], ge_re};
        quo_im[s] <= {qp_im[STEPS-2:0], ge_im};
        dv[s]     <= dp;
        nre[s]    <= np_re;
        nim[s]    <= np_im;
      end
    end
  end

  assign q_re       = quo_re[STEPS-1];
  assign q_im       = quo_im[STEPS-1];
  assign neg_re_out = nre[STEPS-1];
  assign neg_im_out = nim[STEPS-1];

endmodule

// ----- rtl/cau_isqrt.sv -----
// ----------------------------------------------------------------------------
// cau_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cau_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  output logic [31:0] root
);

  localparam int STEPS = cau_pkg::SQRT_STEPS;

  logic [63:0] rem [STEPS];
  logic [31:0] rt  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int I = STEPS - 1 - s;
    logic [63:0] remp;
    logic [31:0] rp;
    logic [64:0] trial;
    logic        ge;

    if (s == 0) begin : g_src
      assign remp = n;
      assign rp   = '0;
    end else begin : g_src
      assign remp = rem[s-1];
      assign rp   = rt[s-1];
    end

    assign trial = ((65'(rp) << 1) + (65'(1) << I)) << I;
    assign ge    = {1'b0, remp} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? remp - trial[63:0] : remp;
        rt[s]  <= ge ? (rp | (32'(1) << I)) : rp;
      end
    end
  end

  assign root = rt[STEPS-1];

endmodule

// ----- rtl/cau_cordic.sv -----
// ----------------------------------------------------------------------------
// cau_cordic
// Pipelined argument unit: axis detection, staged normalization, CORDIC
// vectoring one iteration per stage, quadrant mapping and rounding.
// ----------------------------------------------------------------------------
module cau_cordic #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] re,
  input  logic signed [31:0] im,
  output logic [31:0]        angle
);

  localparam int CW = cau_pkg::CORDIC_W;
  localparam int NS = cau_pkg::NORM_STEPS;
  localparam int S  = 30 - FRAC_BITS;
  localparam logic [34:0] HALF_LSB = 35'(1) << (S - 1);
  localparam logic [34:0] WRAP     = (cau_pkg::Q30_TWO_PI + HALF_LSB) >> S;

  typedef struct packed {
    logic                 axis;
    logic [34:0]          axis_val;
    logic                 re_neg;
    logic                 im_neg;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [33:0]   z;
  } ang_t;

  ang_t        pre;
  ang_t        pre_next;
  ang_t        nrm [NS];
  ang_t        itr [CORDIC_ITERS];
  logic [31:0] abs_re;
  logic [31:0] abs_im;
  logic [34:0] zc;
  logic [34:0] mapped_next;
  logic [34:0] mapped;
  logic [34:0] conv;

  assign abs_re = re[31] ? (~re) + 32'd1 : re;
  assign abs_im = im[31] ? (~im) + 32'd1 : im;

  always_comb begin
    pre_next.axis   = (re == 32'sd0) || (im == 32'sd0);
    pre_next.re_neg = re[31];
    pre_next.im_neg = im[31];
    pre_next.x      = $signed(CW'(abs_re) << 9);
    pre_next.y      = $signed(CW'(abs_im) << 9);
    pre_next.z      = '0;
    if (im == 32'sd0) begin
      pre_next.axis_val = re[31] ? cau_pkg::Q30_PI : 35'd0;
    end else begin
      pre_next.axis_val = im[31] ? cau_pkg::Q30_3HALF_PI : cau_pkg::Q30_HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre <= pre_next;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_norm
    localparam int K = 16 >> s;
    localparam logic [CW-1:0] LIM = CW'(1) << (41 - K);
    ang_t p;
    ang_t nxt;

    if (s == 0) begin : g_src
      assign p = pre;
    end else begin : g_src
      assign p = nrm[s-1];
    end

    always_comb begin
      nxt = p;
      if (($unsigned(p.x) < LIM) && ($unsigned(p.y) < LIM)) begin
        nxt.x = p.x <<< K;
        nxt.y = p.y <<< K;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm[s] <= nxt;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam logic [33:0] ATAN = 34'(cau_pkg::atan_q30(5'(i)));
    ang_t p;
    ang_t nxt;

    if (i == 0) begin : g_src
      assign p = nrm[NS-1];
    end else begin : g_src
      assign p = itr[i-1];
    end

    always_comb begin
      nxt = p;
      if (!p.y[CW-1]) begin
        nxt.x = p.x + (p.y >>> i);
        nxt.y = p.y - (p.x >>> i);
        nxt.z = p.z + $signed(ATAN);
      end else begin
        nxt.x = p.x - (p.y >>> i);
        nxt.y = p.y + (p.x >>> i);
        nxt.z = p.z - $signed(ATAN);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itr[i] <= nxt;
      end
    end
  end

  always_comb begin
    if (itr[CORDIC_ITERS-1].z[33]) begin
      zc = '0;
    end else if (35'(itr[CORDIC_ITERS-1].z[32:0]) > cau_pkg::Q30_HALF_PI) begin
      zc = cau_pkg::Q30_HALF_PI;
    end else begin
      zc = 35'(itr[CORDIC_ITERS-1].z[32:0]);
    end

    if (itr[CORDIC_ITERS-1].axis) begin
      mapped_next = itr[CORDIC_ITERS-1].axis_val;
    end else begin
      case ({itr[CORDIC_ITERS-1].re_neg, itr[CORDIC_ITERS-1].im_neg})
        2'b00:   mapped_next = zc;
        2'b10:   mapped_next = cau_pkg::Q30_PI - zc;
        2'b11:   mapped_next = cau_pkg::Q30_PI + zc;
        default: mapped_next = cau_pkg::Q30_TWO_PI - zc;
      endcase
    end
  end

  assign conv = (mapped + HALF_LSB) >> S;

  always_ff @(posedge clk) begin
    if (en) begin
      mapped <= mapped_next;
      angle  <= (conv >= WRAP) ? 32'd0 : conv[31:0];
    end
  end

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex-number ALU in signed fixed point: add, subtract, multiply, divide,
// scale, conjugate, magnitude, argument and equality within a tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with func and operands a, b; results
//   leave on out_valid/out_ready, one per request, in request order.
//   cfg_write_en/cfg_write_data set the equality tolerance (reset value 1).
//   Requests pass stages A, B and C, the long units and the output register.
//   The divider's 34 quotient-bit stages set the long-unit depth unless the
//   CORDIC chain is longer. One request is accepted every cycle unless stalled.
//   The whole pipeline advances together: when the output register holds a
//   result that is not taken, every stage holds and in_ready drops; nothing
//   is lost or repeated. Reset empties the pipeline and restores the
//   tolerance; no clearing pass is needed.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         func,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               equal,
  output logic               div_zero,
  output logic               saturated
);

  localparam int DIV_LAT  = cau_pkg::DIV_STEPS;
  localparam int SQRT_LAT = cau_pkg::SQRT_STEPS;
  localparam int ANG_LAT  = CORDIC_ITERS + cau_pkg::ANG_EXTRA;
  localparam int MAX_DS   = (DIV_LAT > SQRT_LAT) ? DIV_LAT : SQRT_LAT;
  localparam int UNIT_LAT = (MAX_DS > ANG_LAT) ? MAX_DS : ANG_LAT;
  localparam int DIV_PAD  = UNIT_LAT - DIV_LAT;
  localparam int SQRT_PAD = UNIT_LAT - SQRT_LAT;
  localparam int ANG_PAD  = UNIT_LAT - ANG_LAT;
  localparam int QW       = cau_pkg::DIV_STEPS;
  localparam int DW       = 2 * QW + 2;

  logic        advance;
  logic [15:0] tol;

  // stage A
  logic               va;
  logic [3:0]         sa_func;
  logic signed [31:0] sa_re;
  logic signed [31:0] sa_im;
  logic signed [63:0] sa_m0, sa_m1, sa_m2, sa_m3, sa_m4, sa_m5;
  cau_pkg::early_t    sa_simple;
  // stage B
  logic               vb;
  logic [3:0]         sb_func;
  logic signed [31:0] sb_re;
  logic signed [31:0] sb_im;
  logic signed [64:0] sb_p_re;
  logic signed [64:0] sb_p_im;
  logic [63:0]        sb_sq;
  cau_pkg::early_t    sb_simple;
  // stage C
  logic               vc;
  logic signed [31:0] sc_re;
  logic signed [31:0] sc_im;
  logic               sc_neg_re, sc_neg_im;
  logic [63:0]        sc_mag_re, sc_mag_im;
  logic [63:0]        sc_sq;
  cau_pkg::early_t    sc_early;

  logic [UNIT_LAT-1:0] vu;

  logic signed [31:0] sx, sy;
  logic signed [63:0] m0, m1, m2, m3, m4, m5;
  logic [32:0]        dr_abs, di_abs;
  logic signed [32:0] dr, di;
  cau_pkg::sat_t      t_re, t_im;
  cau_pkg::early_t    simple;
  logic signed [64:0] p_re, p_im;
  cau_pkg::sat_t      f_re, f_im;
  cau_pkg::early_t    early_next;

  logic [QW-1:0]   du_q_re, du_q_im;
  logic            du_neg_re, du_neg_im;
  logic [DW-1:0]   div_raw, div_dly;
  logic [31:0]     sq_raw, sq_dly;
  logic [31:0]     ang_raw, ang_dly;
  cau_pkg::early_t side;
  cau_pkg::sat_t   dq_re, dq_im;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 16'd1;
    end else if (cfg_write_en) begin
      tol <= cfg_write_data;
    end
  end

  // stage A: products and the simple operations (add, subtract, conjugate, equality)
  assign sx = (func == cau_pkg::FUNC_MAG) ? a_re : b_re;
  assign sy = (func == cau_pkg::FUNC_MAG) ? a_im : b_im;
  assign m0 = a_re * b_re;
  assign m1 = a_im * b_im;
  assign m2 = a_re * b_im;
  assign m3 = a_im * b_re;
  assign m4 = sx * sx;
  assign m5 = sy * sy;

  assign dr     = 33'(a_re) - 33'(b_re);
  assign di     = 33'(a_im) - 33'(b_im);
  assign dr_abs = dr[32] ? 33'(-dr) : 33'(dr);
  assign di_abs = di[32] ? 33'(-di) : 33'(di);

  always_comb begin
    simple      = '0;
    simple.func = func;
    t_re        = '0;
    t_im        = '0;
    case (func)
      cau_pkg::FUNC_ADD: begin
        t_re = cau_pkg::sat65(65'(a_re) + 65'(b_re));
        t_im = cau_pkg::sat65(65'(a_im) + 65'(b_im));
      end
      cau_pkg::FUNC_SUB: begin
        t_re = cau_pkg::sat65(65'(a_re) - 65'(b_re));
        t_im = cau_pkg::sat65(65'(a_im) - 65'(b_im));
      end
      cau_pkg::FUNC_CONJ: begin
        t_re.val = a_re;
        t_im     = cau_pkg::sat65(-65'(a_im));
      end
      cau_pkg::FUNC_EQUAL: begin
        simple.eq = (dr_abs < 33'(tol)) && (di_abs < 33'(tol));
      end
      default: begin
      end
    endcase
    simple.re  = t_re.val;
    simple.im  = t_im.val;
    simple.sat = t_re.sat || t_im.sat;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sa_func   <= func;
      sa_re     <= a_re;
      sa_im     <= a_im;
      sa_m0     <= m0;
      sa_m1     <= m1;
      sa_m2     <= m2;
      sa_m3     <= m3;
      sa_m4     <= m4;
      sa_m5     <= m5;
      sa_simple <= simple;
    end
  end

  // stage B: sums of products
  always_comb begin
    case (sa_func)
      cau_pkg::FUNC_MUL: begin
        p_re = 65'(sa_m0) - 65'(sa_m1);
        p_im = 65'(sa_m2) + 65'(sa_m3);
      end
      cau_pkg::FUNC_DIV: begin
        p_re = 65'(sa_m0) + 65'(sa_m1);
        p_im = 65'(sa_m3) - 65'(sa_m2);
      end
      cau_pkg::FUNC_SCALE: begin
        p_re = 65'(sa_m0);
        p_im = 65'(sa_m3);
      end
      default: begin
        p_re = '0;
        p_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sb_func   <= sa_func;
      sb_re     <= sa_re;
      sb_im     <= sa_im;
      sb_p_re   <= p_re;
      sb_p_im   <= p_im;
      sb_sq     <= $unsigned(sa_m4) + $unsigned(sa_m5);
      sb_simple <= sa_simple;
    end
  end

  // stage C: product scaling and saturation, divider operand prep
  assign f_re = cau_pkg::sat65(sb_p_re >>> FRAC_BITS);
  assign f_im = cau_pkg::sat65(sb_p_im >>> FRAC_BITS);

  always_comb begin
    early_next = sb_simple;
    if (sb_func inside {cau_pkg::FUNC_MUL, cau_pkg::FUNC_SCALE}) begin
      early_next.re  = f_re.val;
      early_next.im  = f_im.val;
      early_next.sat = f_re.sat || f_im.sat;
    end
    early_next.dz = (sb_sq == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sc_re     <= sb_re;
      sc_im     <= sb_im;
      sc_neg_re <= sb_p_re[64];
      sc_neg_im <= sb_p_im[64];
      sc_mag_re <= sb_p_re[64] ? 64'(-sb_p_re) : sb_p_re[63:0];
      sc_mag_im <= sb_p_im[64] ? 64'(-sb_p_im) : sb_p_im[63:0];
      sc_sq     <= sb_sq;
      sc_early  <= early_next;
    end
  end

  // long units
  cau_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .en         (advance),
    .neg_re     (sc_neg_re),
    .neg_im     (sc_neg_im),
    .mag_re     (sc_mag_re),
    .mag_im     (sc_mag_im),
    .d          (sc_sq),
    .q_re       (du_q_re),
    .q_im       (du_q_im),
    .neg_re_out (du_neg_re),
    .neg_im_out (du_neg_im)
  );

  cau_isqrt u_sqrt (
    .clk  (clk),
    .en   (advance),
    .n    (sc_sq),
    .root (sq_raw)
  );

  cau_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk   (clk),
    .en    (advance),
    .re    (sc_re),
    .im    (sc_im),
    .angle (ang_raw)
  );

  assign div_raw = {du_neg_re, du_neg_im, du_q_re, du_q_im};

  if (DIV_PAD > 0) begin : g_div_pad
    cau_delay #(.W(DW), .N(DIV_PAD)) u_dly (
      .clk (clk), .en (advance), .d (div_raw), .q (div_dly)
    );
  end else begin : g_div_pad
    assign div_dly = div_raw;
  end

  if (SQRT_PAD > 0) begin : g_sqrt_pad
    cau_delay #(.W(32), .N(SQRT_PAD)) u_dly (
      .clk (clk), .en (advance), .d (sq_raw), .q (sq_dly)
    );
  end else begin : g_sqrt_pad
    assign sq_dly = sq_raw;
  end

  if (ANG_PAD > 0) begin : g_ang_pad
    cau_delay #(.W(32), .N(ANG_PAD)) u_dly (
      .clk (clk), .en (advance), .d (ang_raw), .q (ang_dly)
    );
  end else begin : g_ang_pad
    assign ang_dly = ang_raw;
  end

  cau_delay #(
    .W ($bits(cau_pkg::early_t)),
    .N (UNIT_LAT)
  ) u_side (
    .clk (clk),
    .en  (advance),
    .d   (sc_early),
    .q   (side)
  );

  // output stage
  assign dq_re = cau_pkg::div_final(div_dly[DW-1], div_dly[2*QW-1:QW]);
  assign dq_im = cau_pkg::div_final(div_dly[DW-2], div_dly[QW-1:0]);

  always_ff @(posedge clk) begin
    if (advance) begin
      res_re    <= side.re;
      res_im    <= side.im;
      equal     <= side.eq;
      div_zero  <= 1'b0;
      saturated <= side.sat;
      case (side.func)
        cau_pkg::FUNC_DIV: begin
          div_zero  <= side.dz;
          res_re    <= side.dz ? 32'sd0 : dq_re.val;
          res_im    <= side.dz ? 32'sd0 : dq_im.val;
          saturated <= !side.dz && (dq_re.sat || dq_im.sat);
        end
        cau_pkg::FUNC_MAG: begin
          res_re    <= sq_dly[31] ? cau_pkg::S32_MAX : sq_dly;
          res_im    <= 32'sd0;
          saturated <= sq_dly[31];
        end
        cau_pkg::FUNC_ARG: begin
          res_re    <= ang_dly;
          res_im    <= 32'sd0;
          saturated <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vu        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vu        <= {vu[UNIT_LAT-2:0], vc};
      out_valid <= vu[UNIT_LAT-1];
    end
  end

endmodule

// ----- rtl/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex-number ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_write_en,
  input logic [15:0]        cfg_write_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic [3:0]         func,
  input logic signed [31:0] a_re,
  input logic signed [31:0] a_im,
  input logic signed [31:0] b_re,
  input logic signed [31:0] b_im,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] res_re,
  input logic signed [31:0] res_im,
  input logic               equal,
  input logic               div_zero,
  input logic               saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output register");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_re == 32'sd0 && res_im == 32'sd0 && !saturated && !equal)
    else $error("divide by zero result not cleared");

  a_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && equal |-> !div_zero && !saturated && res_re == 32'sd0 && res_im == 32'sd0)
    else $error("equality result carries other fields");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
